@@ design/mgrb_pkg.sv @@
package mgrb_pkg;

   localparam int ROW_BYTES   = 16;
   localparam int LINES       = 64;
   localparam int GLYPH_BYTES = 4;

   localparam int STORE_SIZE  = ROW_BYTES * LINES;
   localparam int ROW_PIXELS  = ROW_BYTES * 8;
   localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

   // glyph_bits carries this many bytes; further glyph bytes read as zero
   localparam int GBITS_BYTES = 4;
   localparam int GEXT_BYTES  = (GLYPH_BYTES > GBITS_BYTES) ? GLYPH_BYTES : GBITS_BYTES;
   localparam int GEXT_W      = 8 * GEXT_BYTES;

   // shift window: glyph span plus one spill byte
   localparam int WIN_BYTES   = GLYPH_BYTES + 1;
   localparam int WIN_W       = 8 * WIN_BYTES;

   localparam int BIDX_W      = $clog2(ROW_BYTES + GLYPH_BYTES + 1);
   localparam int STEP_W      = 4;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] PIX_MSB   = 8'h80;

   typedef enum logic [1:0] {
      KIND_GLYPH = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_READ  = 2'd2,
      KIND_WRITE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_MODIFY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  x_pos;
      logic [5:0]  line;
      logic [31:0] glyph_bits;
      logic [2:0]  glyph_bytes;
      logic        pixel_on;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic wr_raw;
      logic rd_issue;
      logic merge;
      logic advance;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic     clear_last;
      logic     ok;
      kind_type kind;
      logic     steps_zero;
      logic     last;
      logic     slot_free;
   } sts_type;

endpackage

@@ design/mgrb_ram.sv @@
module mgrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/mgrb_ctrl.sv @@
module mgrb_ctrl
   import mgrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (!sts.ok || sts.steps_zero) state_in = ST_FINISH;
            else state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (sts.last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_ISSUE: begin
            if (!sts.ok || sts.steps_zero) begin
               cmd.wr_raw = sts.ok && (sts.kind == KIND_WRITE);
            end else begin
               cmd.rd_issue = 1'b1;
            end
         end
         ST_MODIFY: begin
            cmd.merge   = 1'b1;
            cmd.advance = !sts.last;
         end
         ST_FINISH: begin
            cmd.emit = sts.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ design/mgrb_dp.sv @@
module mgrb_dp
   import mgrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   kind_type             kind_ff, kind_in;
   logic                 ok_ff, ok_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [WIN_W-1:0]     gdata_ff, gdata_in;
   logic [WIN_W-1:0]     gmask_ff, gmask_in;
   logic [BIDX_W-1:0]    bidx_ff, bidx_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [7:0]           wbyte_ff, wbyte_in;
   logic [7:0]           rdata_ff, rdata_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [2:0]           ld_shift;
   logic [STEP_W-1:0]    ld_n;
   logic [GEXT_W-1:0]    ld_gext;
   logic [WIN_W-1:0]     ld_base_data, ld_base_mask;
   logic                 ld_ok;
   logic [STEP_W-1:0]    ld_steps;
   logic [BIDX_W-1:0]    ld_bidx;
   logic [ADDR_W-1:0]    ld_addr;

   logic                 ram_we, ram_re;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [7:0]           ram_wdata, ram_rdata;
   logic [7:0]           cur_data, cur_mask;
   logic                 pix_kind;

   always_comb begin
      ld_shift = req_data.x_pos[2:0];
      ld_gext  = GEXT_W'(req_data.glyph_bits);
      if (int'(req_data.glyph_bytes) > GLYPH_BYTES) ld_n = STEP_W'(GLYPH_BYTES);
      else ld_n = STEP_W'(req_data.glyph_bytes);

      ld_base_data = '0;
      ld_base_mask = '0;
      ld_ok        = 1'b0;
      ld_steps     = '0;
      ld_bidx      = BIDX_W'(req_data.x_pos);
      case (req_data.kind)
         KIND_GLYPH: begin
            for (int k = 0; k < GLYPH_BYTES; k++) begin
               ld_base_data[WIN_W-1-8*k -: 8] = ~ld_gext[8*k +: 8];
               if (k < int'(ld_n)) ld_base_mask[WIN_W-1-8*k -: 8] = BYTE_ONES;
            end
            ld_ok    = int'(req_data.x_pos) < ROW_PIXELS;
            ld_steps = (ld_n == '0) ? '0 : ld_n + STEP_W'(1);
            ld_bidx  = BIDX_W'(req_data.x_pos[6:3]);
         end
         KIND_PIXEL: begin
            ld_base_data[WIN_W-1 -: 8] = {8{~req_data.pixel_on}};
            ld_base_mask[WIN_W-1 -: 8] = PIX_MSB;
            ld_ok    = int'(req_data.x_pos) < ROW_PIXELS;
            ld_steps = STEP_W'(1);
            ld_bidx  = BIDX_W'(req_data.x_pos[6:3]);
         end
         KIND_READ: begin
            ld_ok    = int'(req_data.x_pos) < ROW_BYTES;
            ld_steps = STEP_W'(1);
         end
         default: begin
            ld_ok    = int'(req_data.x_pos) < ROW_BYTES;
            ld_steps = '0;
         end
      endcase
      ld_ok   = ld_ok && (int'(req_data.line) < LINES);
      ld_addr = ADDR_W'(int'(req_data.line) * ROW_BYTES + int'(ld_bidx));
   end

   assign cur_data = gdata_ff[WIN_W-1 -: 8];
   assign cur_mask = gmask_ff[WIN_W-1 -: 8];
   assign pix_kind = (kind_ff == KIND_GLYPH) || (kind_ff == KIND_PIXEL);

   always_comb begin
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      steps_in     = steps_ff;
      gdata_in     = gdata_ff;
      gmask_in     = gmask_ff;
      bidx_in      = bidx_ff;
      addr_in      = addr_ff;
      wbyte_in     = wbyte_ff;
      rdata_in     = rdata_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.clear) clr_in = clr_ff + ADDR_W'(1);

      if (cmd.load) begin
         kind_in  = req_data.kind;
         ok_in    = ld_ok;
         steps_in = ld_steps;
         gdata_in = ld_base_data >> ld_shift;
         gmask_in = ld_base_mask >> ld_shift;
         bidx_in  = ld_bidx;
         addr_in  = ld_addr;
         wbyte_in = req_data.write_byte;
         rdata_in = '0;
      end

      if (cmd.merge && (kind_ff == KIND_READ)) rdata_in = ram_rdata;

      if (cmd.advance) begin
         steps_in = steps_ff - STEP_W'(1);
         gdata_in = gdata_ff << 8;
         gmask_in = gmask_ff << 8;
         bidx_in  = bidx_ff + BIDX_W'(1);
         addr_in  = addr_ff + ADDR_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.accepted  = ok_ff;
         rsp_data_in.read_data = rdata_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      ok_ff       <= ok_in;
      steps_ff    <= steps_in;
      gdata_ff    <= gdata_in;
      gmask_ff    <= gmask_in;
      bidx_ff     <= bidx_in;
      addr_ff     <= addr_in;
      wbyte_ff    <= wbyte_in;
      rdata_ff    <= rdata_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = wbyte_ff;
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = BYTE_ONES;
      end else if (cmd.wr_raw) begin
         ram_we = 1'b1;
      end else if (cmd.merge && pix_kind && (int'(bidx_ff) < ROW_BYTES)) begin
         ram_we    = 1'b1;
         ram_wdata = (ram_rdata & ~cur_mask) | (cur_data & cur_mask);
      end
      ram_re    = cmd.rd_issue || cmd.advance;
      ram_raddr = cmd.advance ? addr_ff + ADDR_W'(1) : addr_ff;
   end

   mgrb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      sts.clear_last = (clr_ff == ADDR_W'(STORE_SIZE - 1));
      sts.ok         = ok_ff;
      sts.kind       = kind_ff;
      sts.steps_zero = (steps_ff == '0);
      sts.last       = (steps_ff == STEP_W'(1));
      sts.slot_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/mono_glyph_row_blitter.sv @@
// One-bit-per-pixel, active-low frame store with glyph-row, pixel, byte
// read and byte write items on the req_ channel; one result item per
// request on the rsp_ channel (accepted flag and read byte).
// After reset the store is swept to all ones, one byte per cycle, over
// all STORE_SIZE (1024) bytes; req_stall stays high during the sweep.
// A request is taken only while the block is idle. Every item passes the
// ISSUE and FINISH states; a glyph row with n bytes (n saturated to
// GLYPH_BYTES), a pixel write and a byte read also pass MODIFY, where a glyph
// row does one read-modify-write of a frame byte per cycle, n + 1 bytes
// (bytes past the row end are read but not written). A glyph row with zero
// bytes, a byte write or a rejected item goes from ISSUE to FINISH.
// The frame RAM has one write and one registered read port; the next
// byte is read while the current one is written.
// The result sits in an output register, which FINISH loads after the last
// store write. If the receiver stalls, the block accepts the next request
// and holds its own result until the register frees up.
module mono_glyph_row_blitter
   import mgrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   mgrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mgrb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/mgrb_checker.sv @@
module mgrb_checker
   import mgrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      checked
);

   logic [7:0] shadow_frame [STORE_SIZE];
   rsp_type    expected_rsp [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      fail_count++;
   endtask

   function automatic void set_pixel(int unsigned base, int unsigned col, logic stored);
      int unsigned addr;
      logic [7:0]  mask;
      addr = base + col / 8;
      mask = PIX_MSB >> (col % 8);
      if (addr < STORE_SIZE) begin
         if (stored)
            shadow_frame[addr[ADDR_W-1:0]] = shadow_frame[addr[ADDR_W-1:0]] | mask;
         else
            shadow_frame[addr[ADDR_W-1:0]] = shadow_frame[addr[ADDR_W-1:0]] & ~mask;
      end
   endfunction

   // updates the shadow frame and returns the result the item should produce
   function automatic rsp_type apply_request(req_type r);
      rsp_type     res;
      int unsigned base, nbytes, k, col, addr, i;
      logic [7:0]  gbyte;
      res  = '0;
      base = r.line * ROW_BYTES;
      if (r.line < LINES) begin
         case (r.kind)
            KIND_GLYPH: begin
               if (r.x_pos < ROW_PIXELS) begin
                  nbytes = (r.glyph_bytes > GLYPH_BYTES) ? GLYPH_BYTES : r.glyph_bytes;
                  for (i = 0; i < nbytes * 8; i++) begin
                     k     = i / 8;
                     gbyte = (k < GBITS_BYTES) ? r.glyph_bits[5'(8*k) +: 8] : 8'h00;
                     col   = r.x_pos + i;
                     if (col < ROW_PIXELS)
                        set_pixel(base, col, ~gbyte[3'(7 - (i % 8))]);
                  end
                  res.accepted = 1'b1;
               end
            end
            KIND_PIXEL: begin
               if (r.x_pos < ROW_PIXELS) begin
                  set_pixel(base, 32'(r.x_pos), ~r.pixel_on);
                  res.accepted = 1'b1;
               end
            end
            KIND_READ, KIND_WRITE: begin
               addr = base + r.x_pos;
               if (r.x_pos < ROW_BYTES && addr < STORE_SIZE) begin
                  if (r.kind == KIND_READ)
                     res.read_data = shadow_frame[addr[ADDR_W-1:0]];
                  else
                     shadow_frame[addr[ADDR_W-1:0]] = r.write_byte;
                  res.accepted = 1'b1;
               end
            end
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (shadow_frame[a])
            shadow_frame[a] = BYTE_ONES;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.accepted !== want.accepted)
                  report_mismatch($sformatf("accepted got %b want %b",
                                            rsp_data.accepted, want.accepted));
               if (rsp_data.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data got %h want %h",
                                            rsp_data.read_data, want.read_data));
               checked++;
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(apply_request(req_data));
      end
      pending = expected_rsp.size();
   end

endmodule

@@ dv/tb_top.sv @@
module tb_top
   import mgrb_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 600;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count;
   int pending_results;
   int results_checked;
   int cycle_count;
   int n_glyph, n_pixel, n_read, n_write, n_reject;
   bit calm;

   mono_glyph_row_blitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mgrb_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending_results),
      .checked    (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic req_type make_item(kind_type k, int x, int ln, logic [31:0] g,
                                         int nb, logic pon, logic [7:0] wb);
      req_type r;
      r.kind        = k;
      r.x_pos       = 7'(x);
      r.line        = 6'(ln);
      r.glyph_bits  = g;
      r.glyph_bytes = 3'(nb);
      r.pixel_on    = pon;
      r.write_byte  = wb;
      return r;
   endfunction

   // mostly a handful of lines so reads see earlier writes; byte kinds
   // mostly in range
   function automatic req_type random_item();
      req_type r;
      int      roll;
      r.glyph_bits  = $urandom;
      r.pixel_on    = 1'($urandom_range(0, 1));
      r.write_byte  = 8'($urandom_range(0, 255));
      r.glyph_bytes = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 4))
                                                 : 3'($urandom_range(0, 7));
      r.line        = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 3))
                                                 : 6'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 35)
         r.kind = KIND_GLYPH;
      else if (roll < 55)
         r.kind = KIND_PIXEL;
      else if (roll < 85)
         r.kind = KIND_READ;
      else
         r.kind = KIND_WRITE;
      if (r.kind == KIND_READ || r.kind == KIND_WRITE)
         r.x_pos = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, ROW_BYTES - 1))
                                                : 7'($urandom_range(ROW_BYTES, 127));
      else
         r.x_pos = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(100, 127))
                                               : 7'($urandom_range(0, 127));
      return r;
   endfunction

   task automatic send_item(req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      case (r.kind)
         KIND_GLYPH: n_glyph++;
         KIND_PIXEL: n_pixel++;
         KIND_READ:  n_read++;
         KIND_WRITE: n_write++;
      endcase
      if ((r.kind == KIND_READ || r.kind == KIND_WRITE) && r.x_pos >= ROW_BYTES)
         n_reject++;
   endtask

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      n_glyph  = 0;
      n_pixel  = 0;
      n_read   = 0;
      n_write  = 0;
      n_reject = 0;
      calm     = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: edges of the row, spill past the end, saturation, rejects
      send_item(make_item(KIND_READ,  0,   0,  32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 0,   0,  32'hFFFF_FFFF, 4, 1'b0, 8'h00));
      send_item(make_item(KIND_READ,  0,   0,  32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_READ,  3,   0,  32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 3,   1,  32'hA5C3_0F81, 3, 1'b0, 8'h00));
      send_item(make_item(KIND_READ,  3,   1,  32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 127, 2,  32'hFFFF_FFFF, 4, 1'b1, 8'hFF));
      send_item(make_item(KIND_READ,  15,  2,  32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 121, 63, 32'h1234_5678, 7, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 100, 62, 32'h0000_0000, 5, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 64,  5,  32'hFFFF_FFFF, 0, 1'b0, 8'h00));
      send_item(make_item(KIND_READ,  8,   5,  32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_GLYPH, 9,   62, 32'h8001_7FFE, 6, 1'b0, 8'h00));
      send_item(make_item(KIND_PIXEL, 0,   63, 32'h0,         1, 1'b1, 8'h00));
      send_item(make_item(KIND_PIXEL, 127, 63, 32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_PIXEL, 127, 0,  32'h0,         1, 1'b1, 8'h00));
      send_item(make_item(KIND_READ,  0,   63, 32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_READ,  15,  63, 32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_WRITE, 15,  63, 32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_WRITE, 0,   3,  32'h0,         1, 1'b0, 8'hFF));
      send_item(make_item(KIND_WRITE, 16,  1,  32'h0,         1, 1'b0, 8'h5A));
      send_item(make_item(KIND_READ,  127, 63, 32'h0,         1, 1'b0, 8'h00));
      send_item(make_item(KIND_WRITE, 127, 0,  32'h0,         1, 1'b0, 8'hA5));
      send_item(make_item(KIND_READ,  15,  63, 32'h0,         1, 1'b0, 8'h00));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = ((i / 75) % 3 == 1);
         send_item(random_item());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d items: %0d glyph rows, %0d pixels, %0d byte reads, %0d byte writes",
               n_glyph + n_pixel + n_read + n_write, n_glyph, n_pixel, n_read, n_write);
      $display("%0d out-of-range byte items, %0d results checked in %0d cycles",
               n_reject, results_checked, cycle_count);
      if (fail_count == 0 && pending_results == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
design/mgrb_pkg.sv
design/mgrb_ram.sv
design/mgrb_ctrl.sv
design/mgrb_dp.sv
design/mono_glyph_row_blitter.sv
dv/mgrb_checker.sv
dv/tb_top.sv
